### sv/rgbp_pkg.sv
// Shared types, register codes and reset values of the RGBA to bilevel packer.
package rgbp_pkg;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_COMPOSE_MODE   = 3'd0;
	localparam reg_idx_t REG_RED_WEIGHT     = 3'd1;
	localparam reg_idx_t REG_GREEN_WEIGHT   = 3'd2;
	localparam reg_idx_t REG_BLUE_WEIGHT    = 3'd3;
	localparam reg_idx_t REG_LUMA_THRESHOLD = 3'd4;

	localparam logic       RST_COMPOSE_MODE   = 1'b0;
	localparam logic [7:0] RST_RED_WEIGHT     = 8'd77;
	localparam logic [7:0] RST_GREEN_WEIGHT   = 8'd150;
	localparam logic [7:0] RST_BLUE_WEIGHT    = 8'd29;
	localparam logic [7:0] RST_LUMA_THRESHOLD = 8'd46;

	localparam logic [7:0] FULL_ALPHA  = 8'hFF;
	localparam logic [7:0] ZERO_ALPHA  = 8'h00;
	localparam logic [7:0] LUMA_MAX    = 8'hFF;
	localparam logic [2:0] LAST_BIT_POS = 3'd7;

	typedef struct packed {
		logic       compose_mode;
		logic [7:0] red_weight;
		logic [7:0] green_weight;
		logic [7:0] blue_weight;
		logic [7:0] luma_threshold;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       dest_bit;
		logic       row_end;
	} pixel_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_byte;
	} result_t;

	// How the back end decides a pixel's bit.
	typedef enum logic [1:0] {
		CLS_THRESH = 2'd0,
		CLS_KEEP   = 2'd1,
		CLS_BLEND  = 2'd2
	} cls_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] alpha;
		cls_t       cls;
		logic       dest_bit;
		logic       row_end;
	} qent_t;

endpackage

### sv/rgba_to_bilevel_packer_unit.sv
// Top level of the RGBA to bilevel packer: register port, queues, front and back ends.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-------------------------------
//  pixel    | in        | push / full                   | red, green, blue, alpha, ...
//  result   | out       | pop / empty                   | packed_byte, last_byte
//  config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Sustains one pixel per clock while no stall holds the output; the limit is the single
// pixel a cycle that the back end's pack stage retires. A pixel that closes a byte passes
// the input queue, the blend register and the output queue before its result shows.
// Reset clears queue pointers, the blend stage and the bit packer; registers
// return to their reset values. A stalled pop fills the output queue, then
// holds the back end, then raises full once the input queue is full.
module rgba_to_bilevel_packer_unit #(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rgbp_pkg::pixel_t   pixel,
	output logic               empty,
	input  logic               pop,
	output rgbp_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rgbp_pkg::*;

	localparam int QENT_W = $bits(qent_t);
	localparam int RES_W  = $bits(result_t);

	cfg_t             cfg_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	logic             fq_wr, fq_full, fq_pop, fq_empty;
	qent_t            fq_wdata, fq_rdata;
	logic [QENT_W-1:0] fq_rvec;

	logic             oq_wr, oq_full;
	result_t          oq_wdata;
	logic [RES_W-1:0] oq_rvec;

	// Register port: no wait states; decode by word address.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.compose_mode   <= RST_COMPOSE_MODE;
			cfg_q.red_weight     <= RST_RED_WEIGHT;
			cfg_q.green_weight   <= RST_GREEN_WEIGHT;
			cfg_q.blue_weight    <= RST_BLUE_WEIGHT;
			cfg_q.luma_threshold <= RST_LUMA_THRESHOLD;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COMPOSE_MODE:   cfg_q.compose_mode   <= pwdata[0];
				REG_RED_WEIGHT:     cfg_q.red_weight     <= pwdata[7:0];
				REG_GREEN_WEIGHT:   cfg_q.green_weight   <= pwdata[7:0];
				REG_BLUE_WEIGHT:    cfg_q.blue_weight    <= pwdata[7:0];
				REG_LUMA_THRESHOLD: cfg_q.luma_threshold <= pwdata[7:0];
				default:            cfg_q                <= cfg_q; // drop unmapped writes
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COMPOSE_MODE:   prdata = {31'b0, cfg_q.compose_mode};
			REG_RED_WEIGHT:     prdata = {24'b0, cfg_q.red_weight};
			REG_GREEN_WEIGHT:   prdata = {24'b0, cfg_q.green_weight};
			REG_BLUE_WEIGHT:    prdata = {24'b0, cfg_q.blue_weight};
			REG_LUMA_THRESHOLD: prdata = {24'b0, cfg_q.luma_threshold};
			default:            prdata = '0;
		endcase
	end

	// Front end: luma and classification straight into the input queue.
	rgbp_front u_front (
		.cfg    (cfg_q),
		.push   (push),
		.pixel  (pixel),
		.q_full (fq_full),
		.q_wr   (fq_wr),
		.q_data (fq_wdata)
	);

	assign full = fq_full;

	// Queue between the two ends; each side stalls on its own.
	rgbp_fifo #(
		.WIDTH (QENT_W),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_wr),
		.wr_data (fq_wdata),
		.full    (fq_full),
		.rd_en   (fq_pop),
		.rd_data (fq_rvec),
		.empty   (fq_empty)
	);

	assign fq_rdata = qent_t'(fq_rvec);

	// Back end: blend, threshold, pack; hold when the output queue is full.
	rgbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (fq_empty),
		.q_data  (fq_rdata),
		.q_pop   (fq_pop),
		.o_full  (oq_full),
		.o_wr    (oq_wr),
		.o_data  (oq_wdata)
	);

	// Output queue parts the packer from the consumer.
	rgbp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_wr),
		.wr_data (oq_wdata),
		.full    (oq_full),
		.rd_en   (pop),
		.rd_data (oq_rvec),
		.empty   (empty)
	);

	assign result = result_t'(oq_rvec);

endmodule

### sv/rgbp_fifo.sv
// Generic register-based first-in first-out queue with show-ahead read.
module rgbp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/rgbp_front.sv
// Front end: accept pixels, form weighted luma and classify the bit decision.
module rgbp_front (
	input  rgbp_pkg::cfg_t   cfg,
	input  logic             push,
	input  rgbp_pkg::pixel_t pixel,
	input  logic             q_full,
	output logic             q_wr,
	output rgbp_pkg::qent_t  q_data
);
	import rgbp_pkg::*;

	logic [15:0] prod_r, prod_g, prod_b;
	logic [17:0] luma_sum;

	assign prod_r   = pixel.red   * cfg.red_weight;
	assign prod_g   = pixel.green * cfg.green_weight;
	assign prod_b   = pixel.blue  * cfg.blue_weight;
	assign luma_sum = {2'b00, prod_r} + {2'b00, prod_g} + {2'b00, prod_b};

	assign q_wr = push && !q_full;

	always_comb begin
		q_data          = '0;
		// Saturate the truncated luma at full scale.
		q_data.luma     = (luma_sum[17:16] != 2'b00) ? LUMA_MAX : luma_sum[15:8];
		q_data.alpha    = pixel.alpha;
		q_data.dest_bit = pixel.dest_bit;
		q_data.row_end  = pixel.row_end;
		if (!cfg.compose_mode || pixel.alpha == FULL_ALPHA) begin
			q_data.cls = CLS_THRESH;
		end else if (pixel.alpha == ZERO_ALPHA) begin
			q_data.cls = CLS_KEEP;
		end else begin
			q_data.cls = CLS_BLEND;
		end
	end

endmodule

### sv/rgbp_back.sv
// Back end: blend over the destination, threshold and pack bits into bytes.
module rgbp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rgbp_pkg::cfg_t   cfg,
	input  logic             q_empty,
	input  rgbp_pkg::qent_t  q_data,
	output logic             q_pop,
	input  logic             o_full,
	output logic             o_wr,
	output rgbp_pkg::result_t o_data
);
	import rgbp_pkg::*;

	logic        valid_s1;
	logic [15:0] x_s1;
	logic [7:0]  luma_s1;
	cls_t        cls_s1;
	logic        dest_s1;
	logic        row_end_s1;

	logic [7:0]  acc_q;
	logic [2:0]  pos_q;

	logic [15:0] prod_la;
	logic [7:0]  inv_alpha;
	logic [15:0] dest_term;
	logic [16:0] t_round;
	logic [16:0] s_round;
	logic [8:0]  blend_v;
	logic        pix_bit;
	logic [7:0]  acc_next;
	logic        emit;
	logic        consume;
	logic        load;

	// Blend product: luma*alpha + D*(255-alpha), D = 255 for a white destination.
	assign prod_la   = q_data.luma * q_data.alpha;
	assign inv_alpha = FULL_ALPHA - q_data.alpha;
	assign dest_term = q_data.dest_bit ? 16'd0 : ({inv_alpha, 8'h00} - {8'h00, inv_alpha});

	// Divide by 255 rounded to nearest.
	assign t_round = {1'b0, x_s1} + 17'd128;
	assign s_round = t_round + {8'h00, t_round[16:8]};
	assign blend_v = s_round[16:8];

	always_comb begin
		case (cls_s1)
			CLS_THRESH: pix_bit = (luma_s1 < cfg.luma_threshold);
			CLS_KEEP:   pix_bit = dest_s1;
			CLS_BLEND:  pix_bit = (blend_v < {1'b0, cfg.luma_threshold});
			default:    pix_bit = 1'b0;
		endcase
	end

	assign acc_next = acc_q | 8'({7'b0, pix_bit} << (LAST_BIT_POS - pos_q));
	assign emit     = (pos_q == LAST_BIT_POS) || row_end_s1;
	assign consume  = valid_s1 && (!emit || !o_full);
	assign load     = !q_empty && (!valid_s1 || consume);
	assign q_pop    = load;

	assign o_wr               = valid_s1 && emit && !o_full;
	assign o_data.packed_byte = acc_next;
	assign o_data.last_byte   = row_end_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1       <= prod_la + dest_term;
			luma_s1    <= q_data.luma;
			cls_s1     <= q_data.cls;
			dest_s1    <= q_data.dest_bit;
			row_end_s1 <= q_data.row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			pos_q    <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				if (emit) begin
					acc_q <= '0;
					pos_q <= '0;
				end else begin
					acc_q <= acc_next;
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

### sv/rgbp_checker.sv
// Port-level assertions for the RGBA to bilevel packer, bound to its top level.
module rgbp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input rgbp_pkg::result_t result,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [4:0]        paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);
	import rgbp_pkg::*;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	// A waiting result holds until its transfer.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// The input queue fills only through a pixel transfer.
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without a pixel transfer");

	// Mode register reads back the written bit.
	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[4:2] == REG_COMPOSE_MODE) |=>
		((paddr[4:2] != REG_COMPOSE_MODE) || (prdata == {31'b0, $past(pwdata[0])})))
		else $error("compose mode readback mismatch");

	// Weight and threshold registers read back the written byte.
	a_byte_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (paddr[4:2] == REG_RED_WEIGHT || paddr[4:2] == REG_GREEN_WEIGHT ||
		            paddr[4:2] == REG_BLUE_WEIGHT || paddr[4:2] == REG_LUMA_THRESHOLD)) |=>
		((paddr[4:2] != $past(paddr[4:2])) || (prdata == {24'b0, $past(pwdata[7:0])})))
		else $error("byte register readback mismatch");

endmodule

bind rgba_to_bilevel_packer_unit rgbp_checker u_rgbp_checker (.*);

### test/tb_top.sv
// Self-checking testbench of the RGBA to bilevel packer unit.
`timescale 1ns / 1ps

module tb_top;
	import rgbp_pkg::*;

	// Results pass the input queue, blend register and output queue; give the pipeline ample room.
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_SETTING = 100;

	// Indexes past the register map: writes there must leave every register alone.
	localparam reg_idx_t REG_SPARE_LO = 3'd5;
	localparam reg_idx_t REG_SPARE_HI = 3'd7;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	pixel_t      pixel   = '0;
	logic        pop     = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [4:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic        full;
	logic        empty;
	result_t     result;
	logic [31:0] prdata;
	logic        pready;

	rgba_to_bilevel_packer_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Shadow of the register file, the packer state and the bytes still owed.
	cfg_t       cfg_model = '{RST_COMPOSE_MODE, RST_RED_WEIGHT, RST_GREEN_WEIGHT,
		RST_BLUE_WEIGHT, RST_LUMA_THRESHOLD};
	logic [7:0] acc_bits = '0;
	logic [2:0] bit_pos  = '0;
	result_t    bytes_due[$];

	int mismatches    = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Decide whether a pixel comes out dark under the current settings.
	function automatic logic pixel_is_dark(input pixel_t p);
		int unsigned weighted;
		int unsigned blend;
		int unsigned level;
		int unsigned backdrop;
		logic [7:0]  luma;
		weighted = (int'(p.red) * int'(cfg_model.red_weight)
			+ int'(p.green) * int'(cfg_model.green_weight)
			+ int'(p.blue) * int'(cfg_model.blue_weight)) >> 8;
		luma = (weighted > int'(LUMA_MAX)) ? LUMA_MAX : 8'(weighted);
		if (!cfg_model.compose_mode || p.alpha == FULL_ALPHA)
			return luma < cfg_model.luma_threshold;
		if (p.alpha == ZERO_ALPHA)
			return p.dest_bit;
		// Blend against the destination gray level, then divide by 255 rounding to nearest.
		backdrop = p.dest_bit ? 0 : int'(LUMA_MAX);
		blend = int'(luma) * int'(p.alpha) + backdrop * (int'(LUMA_MAX) - int'(p.alpha)) + 128;
		level = (blend + (blend >> 8)) >> 8;
		return level < int'(cfg_model.luma_threshold);
	endfunction

	// Fold one accepted pixel into the byte under construction; queue the byte when it closes.
	task automatic track_pixel(input pixel_t p);
		result_t due;
		acc_bits[LAST_BIT_POS - bit_pos] = pixel_is_dark(p);
		if (bit_pos == LAST_BIT_POS || p.row_end) begin
			due.packed_byte = acc_bits;
			due.last_byte   = p.row_end;
			bytes_due.push_back(due);
			acc_bits = '0;
			bit_pos  = '0;
		end else begin
			bit_pos = bit_pos + 3'd1;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (bytes_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected byte %02h last %0b", got.packed_byte,
				got.last_byte));
			return;
		end
		want = bytes_due.pop_front();
		if (got.packed_byte !== want.packed_byte)
			flag_mismatch($sformatf("packed_byte %02h, want %02h", got.packed_byte,
				want.packed_byte));
		if (got.last_byte !== want.last_byte)
			flag_mismatch($sformatf("last_byte %0b, want %0b", got.last_byte, want.last_byte));
	endtask

	// Watch both transfers at every edge and drive pop with the receiver's idle rate.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				track_pixel(pixel);
			if (pop && !empty)
				check_result(result);
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one pixel after a random gap and hold it until the transfer.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
	endtask

	// Drop push, let the monitor see the last transfer, wait for every owed byte,
	// then let the pipeline empty out.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_COMPOSE_MODE:   return {31'b0, cfg_model.compose_mode};
			REG_RED_WEIGHT:     return {24'b0, cfg_model.red_weight};
			REG_GREEN_WEIGHT:   return {24'b0, cfg_model.green_weight};
			REG_BLUE_WEIGHT:    return {24'b0, cfg_model.blue_weight};
			REG_LUMA_THRESHOLD: return {24'b0, cfg_model.luma_threshold};
			default:            return '0;
		endcase
	endfunction

	// Setup and access phase; junk in the upper data bits must be dropped by the block.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		logic [31:0] data;
		data = ($urandom & 32'hFFFF_FF00) | {24'b0, value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_COMPOSE_MODE:   cfg_model.compose_mode   = data[0];
			REG_RED_WEIGHT:     cfg_model.red_weight     = data[7:0];
			REG_GREEN_WEIGHT:   cfg_model.green_weight   = data[7:0];
			REG_BLUE_WEIGHT:    cfg_model.blue_weight    = data[7:0];
			REG_LUMA_THRESHOLD: cfg_model.luma_threshold = data[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic read_reg(input reg_idx_t idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx))
			flag_mismatch($sformatf("register %0d reads %08h, want %08h", idx, prdata,
				reg_value(idx)));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic compose, input logic [7:0] red_w,
		input logic [7:0] green_w, input logic [7:0] blue_w, input logic [7:0] threshold);
		write_reg(REG_COMPOSE_MODE, {7'b0, compose});
		write_reg(REG_RED_WEIGHT, red_w);
		write_reg(REG_GREEN_WEIGHT, green_w);
		write_reg(REG_BLUE_WEIGHT, blue_w);
		write_reg(REG_LUMA_THRESHOLD, threshold);
	endtask

	function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a, input logic dest, input logic last);
		pixel_t p;
		p.red      = r;
		p.green    = g;
		p.blue     = b;
		p.alpha    = a;
		p.dest_bit = dest;
		p.row_end  = last;
		return p;
	endfunction

	// Bias toward the ends of the range, where saturation and empty weights live.
	function automatic logic [7:0] pick_level();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel(input logic last);
		logic [7:0] a;
		case ($urandom_range(3))
			0:       a = ZERO_ALPHA;
			1:       a = FULL_ALPHA;
			default: a = 8'($urandom_range(255));
		endcase
		return make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), a, 1'($urandom_range(1)), last);
	endfunction

	// Reset values, readback after writes with dirty upper bits, writes past the map.
	task automatic test_register_access();
		for (int i = REG_COMPOSE_MODE; i <= REG_LUMA_THRESHOLD; i++)
			read_reg(reg_idx_t'(i));
		apply_setting(1'b1, 8'hFF, 8'h00, 8'hA5, 8'h5A);
		for (int i = REG_COMPOSE_MODE; i <= REG_LUMA_THRESHOLD; i++)
			read_reg(reg_idx_t'(i));
		write_reg(REG_SPARE_LO, 8'hFF);
		write_reg(REG_SPARE_HI, 8'h00);
		for (int i = REG_COMPOSE_MODE; i <= REG_LUMA_THRESHOLD; i++)
			read_reg(reg_idx_t'(i));
		apply_setting(RST_COMPOSE_MODE, RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
			RST_LUMA_THRESHOLD);
	endtask

	task automatic test_directed_pixels();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Plain mode: alternate dark and white to fill a byte with no row end.
		for (int i = 0; i < 8; i++)
			send_pixel(i % 2 == 0 ? make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0)
				: make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0));
		// One-pixel row, then a row that ends mid-byte.
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 1'b1));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
		send_pixel(make_pixel(8'h10, 8'h00, 8'h20, 8'hFF, 1'b0, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		wait_drained();

		// Full weights saturate the luma; top threshold makes only saturated pixels white.
		apply_setting(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h01, 8'hFF, 1'b0, 1'b0));
		send_pixel(make_pixel(8'h01, 8'h01, 8'h01, 8'h7F, 1'b1, 1'b1));
		wait_drained();

		// Compose mode: transparent keeps the destination, opaque thresholds, partial blends.
		apply_setting(1'b1, RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
			RST_LUMA_THRESHOLD);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, ZERO_ALPHA, 1'b1, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, ZERO_ALPHA, 1'b0, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, FULL_ALPHA, 1'b0, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, FULL_ALPHA, 1'b1, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b1, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFE, 1'b0, 1'b1));
		wait_drained();
	endtask

	// Mostly whole rows of random length; the rest is loose pixels with random row ends.
	task automatic send_rows(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++)
					send_pixel(rand_pixel(i == len - 1));
				sent += len;
			end else begin
				send_pixel(rand_pixel(1'($urandom_range(1))));
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < 4; k++) begin
			wait_drained();
			case (k)
				0: apply_setting(1'b0, RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
					pick_level());
				1: apply_setting(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				2: apply_setting(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				default: apply_setting(1'($urandom_range(1)), pick_level(), pick_level(),
					pick_level(), pick_level());
			endcase
			send_rows(ITEMS_PER_SETTING);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_pixels();
		test_random_traffic(23, 86);
		test_random_traffic(86, 23);
		test_random_traffic(0, 0);
		wait_drained();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
